>>> rtl/core/rrsg_pkg.sv
`default_nettype none

package rrsg_pkg;

   // Default coordinate width of the span generator.
   localparam int COORD_BITS_DEFAULT = 10;

   // Width of the RGB565 color that rides along with each span.
   localparam int COLOR_BITS = 16;

endpackage : rrsg_pkg

`default_nettype wire

>>> rtl/core/rounded_rect_span_generator.sv
`default_nettype none

// Rounded rectangle span generator. Each request word carries a rectangle
// (inclusive bounds), a corner radius, a row and a color, and yields exactly one
// response word with the horizontal fill span of the filled rounded rectangle on
// that row. Rows within the radius of the top edge (checked first) or of the
// bottom edge are corner rows and are narrowed by r - floor(sqrt(r*r - dy*dy)) on
// each side; other rows span left to right. The span flag in tuser is set when
// left <= right and the row lies inside top..bottom; the span ends are sent
// whatever the flag. The block is a fully pipelined datapath: it accepts one word
// per clock unless backpressure from the response side reaches the request side,
// and each word passes through COORD_BITS + 3 registers (three front stages for
// the corner test, the squares and the root operand, then one stage per root bit,
// COORD_BITS - 1 of them, then the output register). Backpressure on the response
// side stalls only the stages that are full, so bubbles are squeezed out and no
// word is lost or repeated.
module rounded_rect_span_generator #(
   parameter int COORD_BITS = rrsg_pkg::COORD_BITS_DEFAULT,
   localparam int REQ_W =
      ((6 * COORD_BITS + rrsg_pkg::COLOR_BITS - 1 + 7) / 8) * 8,
   localparam int RSP_W =
      ((3 * COORD_BITS + 4 + rrsg_pkg::COLOR_BITS + 7) / 8) * 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output      logic             req_tready,
   // rect_left, rect_top, rect_right, rect_bottom, corner_radius, scan_row,
   // fill_color (lowest bits first), zero padded to whole bytes.
   input  wire logic [REQ_W-1:0] req_tdata,
   output      logic             rsp_tvalid,
   input  wire logic             rsp_tready,
   // span_row, span_left, span_right, span_color (lowest bits first),
   // zero padded to whole bytes.
   output      logic [RSP_W-1:0] rsp_tdata,
   // span_valid.
   output      logic             rsp_tuser
);

   import rrsg_pkg::*;

   localparam int CB      = COORD_BITS;
   localparam int RB      = COORD_BITS - 1;
   localparam int SB      = COORD_BITS + 2;
   localparam int SIDE_W  = 4 * COORD_BITS + COLOR_BITS;
   localparam int RSP_RAW = 3 * COORD_BITS + 4 + COLOR_BITS;

   // Request fields.
   logic [CB-1:0]         rect_left;
   logic [CB-1:0]         rect_top;
   logic [CB-1:0]         rect_right;
   logic [CB-1:0]         rect_bottom;
   logic [RB-1:0]         corner_radius;
   logic [CB-1:0]         scan_row;
   logic [COLOR_BITS-1:0] fill_color;

   assign rect_left     = req_tdata[0 +: CB];
   assign rect_top      = req_tdata[CB +: CB];
   assign rect_right    = req_tdata[2*CB +: CB];
   assign rect_bottom   = req_tdata[3*CB +: CB];
   assign corner_radius = req_tdata[4*CB +: RB];
   assign scan_row      = req_tdata[5*CB-1 +: CB];
   assign fill_color    = req_tdata[6*CB-1 +: COLOR_BITS];

   // Handshake chain: a stage takes a new word when it is empty or drains.
   logic a_ready;
   logic b_ready;
   logic c_ready;
   logic root_in_ready;
   logic root_out_valid;
   logic rsp_ready;

   assign rsp_ready  = !rsp_tvalid || rsp_tready;
   assign req_tready = a_ready;

   // ------------------------------------------------------------------
   // Stage A: corner classification and vertical distance.
   // ------------------------------------------------------------------
   logic [CB:0] top_plus_r;
   logic [CB:0] row_plus_r;
   logic        top_hit;
   logic        bottom_hit;
   logic [CB:0] dy;

   logic              a_valid_ff;
   logic [CB-1:0]     a_left_ff;
   logic [CB-1:0]     a_right_ff;
   logic [RB-1:0]     a_radius_ff;
   logic [CB-1:0]     a_row_ff;
   logic [COLOR_BITS-1:0] a_color_ff;
   logic              a_inside_ff;
   logic              a_inside_in;
   logic              a_corner_ff;
   logic              a_corner_in;
   logic              a_far_ff;
   logic              a_far_in;
   logic [RB-1:0]     a_dy_ff;

   always_comb begin
      top_plus_r  = {1'b0, rect_top} + {2'b00, corner_radius};
      row_plus_r  = {1'b0, scan_row} + {2'b00, corner_radius};
      top_hit     = ({1'b0, scan_row} < top_plus_r);
      bottom_hit  = (row_plus_r > {1'b0, rect_bottom});
      dy          = top_hit ? (top_plus_r - {1'b0, scan_row})
                            : (row_plus_r - {1'b0, rect_bottom});
      a_corner_in = top_hit || bottom_hit;
      // At or beyond the radius the root operand is not positive, so dx is 0.
      a_far_in    = (dy >= {2'b00, corner_radius});
      a_inside_in = (scan_row >= rect_top) && (scan_row <= rect_bottom);
   end

   assign a_ready = !a_valid_ff || b_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready) begin
         a_left_ff   <= rect_left;
         a_right_ff  <= rect_right;
         a_radius_ff <= corner_radius;
         a_row_ff    <= scan_row;
         a_color_ff  <= fill_color;
         a_inside_ff <= a_inside_in;
         a_corner_ff <= a_corner_in;
         a_far_ff    <= a_far_in;
         a_dy_ff     <= dy[RB-1:0];
      end
   end

   // ------------------------------------------------------------------
   // Stage B: squares of the radius and of the vertical distance.
   // ------------------------------------------------------------------
   logic                b_valid_ff;
   logic [2*RB-1:0]     b_rr_ff;
   logic [2*RB-1:0]     b_dd_ff;
   logic                b_corner_ff;
   logic                b_far_ff;
   logic [SIDE_W-1:0]   b_side_ff;

   assign b_ready = !b_valid_ff || c_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_ready) begin
         b_rr_ff     <= {{RB{1'b0}}, a_radius_ff} * {{RB{1'b0}}, a_radius_ff};
         b_dd_ff     <= {{RB{1'b0}}, a_dy_ff} * {{RB{1'b0}}, a_dy_ff};
         b_corner_ff <= a_corner_ff;
         b_far_ff    <= a_far_ff;
         b_side_ff   <= {a_color_ff, a_inside_ff, a_row_ff, a_radius_ff,
                         a_right_ff, a_left_ff};
      end
   end

   // ------------------------------------------------------------------
   // Stage C: root operand. A straight row takes r*r, so its root is r and
   // the common span formula below gives left .. right unchanged.
   // ------------------------------------------------------------------
   logic                c_valid_ff;
   logic [2*RB-1:0]     c_sq_ff;
   logic [2*RB-1:0]     c_sq_in;
   logic [SIDE_W-1:0]   c_side_ff;

   always_comb begin
      if (!b_corner_ff) begin
         c_sq_in = b_rr_ff;
      end else if (b_far_ff) begin
         c_sq_in = '0;
      end else begin
         c_sq_in = b_rr_ff - b_dd_ff;
      end
   end

   assign c_ready = !c_valid_ff || root_in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (c_ready) begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (c_ready) begin
         c_sq_ff   <= c_sq_in;
         c_side_ff <= b_side_ff;
      end
   end

   // ------------------------------------------------------------------
   // Root stages.
   // ------------------------------------------------------------------
   logic [RB-1:0]     root;
   logic [SIDE_W-1:0] root_side;

   rrsg_root_pipe #(
      .ROOT_BITS (RB),
      .SIDE_BITS (SIDE_W)
   ) u_root (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (c_valid_ff),
      .in_ready    (root_in_ready),
      .in_radicand (c_sq_ff),
      .in_side     (c_side_ff),
      .out_valid   (root_out_valid),
      .out_ready   (rsp_ready),
      .out_root    (root),
      .out_side    (root_side)
   );

   // ------------------------------------------------------------------
   // Output register: span ends and span flag.
   // ------------------------------------------------------------------
   logic [CB-1:0]         o_left;
   logic [CB-1:0]         o_right;
   logic [RB-1:0]         o_radius;
   logic [CB-1:0]         o_row;
   logic                  o_inside;
   logic [COLOR_BITS-1:0] o_color;
   logic signed [SB-1:0]  xl;
   logic signed [SB-1:0]  xr;

   assign {o_color, o_inside, o_row, o_radius, o_right, o_left} = root_side;

   always_comb begin
      xl = signed'({2'b00, o_left} + {3'b000, o_radius} - {3'b000, root});
      xr = signed'({2'b00, o_right} - {3'b000, o_radius} + {3'b000, root});
   end

   logic                  rsp_valid_ff;
   logic [CB-1:0]         rsp_row_ff;
   logic [SB-1:0]         rsp_left_ff;
   logic [SB-1:0]         rsp_right_ff;
   logic                  rsp_flag_ff;
   logic [COLOR_BITS-1:0] rsp_color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_ready) begin
         rsp_valid_ff <= root_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_ready) begin
         rsp_row_ff   <= o_row;
         rsp_left_ff  <= xl;
         rsp_right_ff <= xr;
         rsp_flag_ff  <= (xl <= xr) && o_inside;
         rsp_color_ff <= o_color;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_flag_ff;
   assign rsp_tdata  = {{(RSP_W - RSP_RAW){1'b0}}, rsp_color_ff,
                        rsp_right_ff, rsp_left_ff, rsp_row_ff};

endmodule : rounded_rect_span_generator

`default_nettype wire

>>> rtl/core/rrsg_root_pipe.sv
`default_nettype none

// Pipelined integer square root, one result bit per register stage.
// A side payload travels with each radicand and leaves with its root.
module rrsg_root_pipe #(
   parameter int ROOT_BITS = 9,
   parameter int SIDE_BITS = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output      logic                   in_ready,
   input  wire logic [2*ROOT_BITS-1:0] in_radicand,
   input  wire logic [SIDE_BITS-1:0]   in_side,
   output      logic                   out_valid,
   input  wire logic                   out_ready,
   output      logic [ROOT_BITS-1:0]   out_root,
   output      logic [SIDE_BITS-1:0]   out_side
);

   localparam int RAD_BITS = 2 * ROOT_BITS;
   localparam int REM_BITS = ROOT_BITS + 3;

   // Index 0 holds the pipe inputs; index k+1 holds the output of stage k.
   logic                 valid_w  [0:ROOT_BITS];
   logic                 ready_w  [0:ROOT_BITS];
   logic [REM_BITS-1:0]  rem_w    [0:ROOT_BITS];
   logic [ROOT_BITS-1:0] root_w   [0:ROOT_BITS];
   logic [RAD_BITS-1:0]  rad_w    [0:ROOT_BITS];
   logic [SIDE_BITS-1:0] side_w   [0:ROOT_BITS];

   assign valid_w[0] = in_valid;
   assign rem_w[0]   = '0;
   assign root_w[0]  = '0;
   assign rad_w[0]   = in_radicand;
   assign side_w[0]  = in_side;
   assign in_ready   = ready_w[0];

   assign ready_w[ROOT_BITS] = out_ready;
   assign out_valid          = valid_w[ROOT_BITS];
   assign out_root           = root_w[ROOT_BITS];
   assign out_side           = side_w[ROOT_BITS];

   for (genvar k = 0; k < ROOT_BITS; k++) begin : g_stage
      logic                 valid_ff;
      logic [REM_BITS-1:0]  rem_ff;
      logic [REM_BITS-1:0]  rem_in;
      logic [ROOT_BITS-1:0] root_ff;
      logic [ROOT_BITS-1:0] root_in;
      logic [RAD_BITS-1:0]  rad_ff;
      logic [RAD_BITS-1:0]  rad_in;
      logic [SIDE_BITS-1:0] side_ff;
      logic [REM_BITS-1:0]  shifted;
      logic [REM_BITS-1:0]  trial;
      logic                 fits;

      // Bring down the next two radicand bits and try appending a one.
      always_comb begin
         shifted = {rem_w[k][REM_BITS-3:0], rad_w[k][RAD_BITS-1:RAD_BITS-2]};
         trial   = {1'b0, root_w[k], 2'b01};
         fits    = (shifted >= trial);
         rem_in  = fits ? (shifted - trial) : shifted;
         root_in = {root_w[k][ROOT_BITS-2:0], fits};
         rad_in  = {rad_w[k][RAD_BITS-3:0], 2'b00};
      end

      assign ready_w[k] = !valid_ff || ready_w[k+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (ready_w[k]) begin
            valid_ff <= valid_w[k];
         end
      end

      always_ff @(posedge clock) begin
         if (ready_w[k]) begin
            rem_ff  <= rem_in;
            root_ff <= root_in;
            rad_ff  <= rad_in;
            side_ff <= side_w[k];
         end
      end

      assign valid_w[k+1] = valid_ff;
      assign rem_w[k+1]   = rem_ff;
      assign root_w[k+1]  = root_ff;
      assign rad_w[k+1]   = rad_ff;
      assign side_w[k+1]  = side_ff;
   end

endmodule : rrsg_root_pipe

`default_nettype wire

>>> rtl/core/rrsg_checker.sv
`default_nettype none

// Port-level checks for the span generator.
module rrsg_checker #(
   parameter int COORD_BITS = rrsg_pkg::COORD_BITS_DEFAULT,
   localparam int REQ_W =
      ((6 * COORD_BITS + rrsg_pkg::COLOR_BITS - 1 + 7) / 8) * 8,
   localparam int RSP_W =
      ((3 * COORD_BITS + 4 + rrsg_pkg::COLOR_BITS + 7) / 8) * 8
) (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_tvalid,
   input wire logic             req_tready,
   input wire logic [REQ_W-1:0] req_tdata,
   input wire logic             rsp_tvalid,
   input wire logic             rsp_tready,
   input wire logic [RSP_W-1:0] rsp_tdata,
   input wire logic             rsp_tuser
);

   import rrsg_pkg::*;

   localparam int SB = COORD_BITS + 2;

   logic signed [SB-1:0] span_left;
   logic signed [SB-1:0] span_right;
   logic                 req_seen;

   assign span_left  = signed'(rsp_tdata[COORD_BITS +: SB]);
   assign span_right = signed'(rsp_tdata[COORD_BITS + SB +: SB]);
   assign req_seen   = req_tvalid && req_tready && (req_tdata[0] || !req_tdata[0]);

   // A flagged span is never empty.
   a_flag_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> span_left <= span_right)
      else $error("flagged span has left beyond right");

   // The response side is empty right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // A stalled response word holds.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
      && $stable(rsp_tuser))
      else $error("stalled response changed");

   // The pipeline never refuses a word while the response side drains.
   a_accepts_when_draining: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("request stalled while responses drain");

   // Right after reset the response side stays empty, even for a word accepted as
   // reset falls.
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) && req_seen |=> !rsp_tvalid)
      else $error("response appeared too early");

endmodule : rrsg_checker

bind rounded_rect_span_generator rrsg_checker #(
   .COORD_BITS (COORD_BITS)
) u_rrsg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
